### sv/keyed_weighted_score_accumulator_top_defines.svh
// Assertion macros for the checker file of the score accumulator.
`ifndef KEYED_WEIGHTED_SCORE_ACCUMULATOR_TOP_DEFINES_SVH
`define KEYED_WEIGHTED_SCORE_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define KWSA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kwsa check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define KWSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kwsa check failed: next-cycle implication");

`endif

### sv/kwsa_pkg.sv
`default_nettype none

package kwsa_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 32;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_DUMP = 1'b1;

   localparam logic [7:0] CODE_P = 8'h50;
   localparam logic [7:0] CODE_S = 8'h53;
   localparam logic [7:0] CODE_C = 8'h43;
   localparam logic [7:0] CODE_L = 8'h4C;
   localparam logic [7:0] CODE_D = 8'h44;

   localparam logic signed [7:0] WEIGHT_P = 8'sd50;
   localparam logic signed [7:0] WEIGHT_S = 8'sd40;
   localparam logic signed [7:0] WEIGHT_C = 8'sd30;
   localparam logic signed [7:0] WEIGHT_L = 8'sd20;
   localparam logic signed [7:0] WEIGHT_D = -8'sd10;

   typedef struct packed {
      logic        cmd;
      logic [31:0] user_key;
      logic [7:0]  action_code;
      logic [63:0] topic_upper;
      logic [47:0] topic_lower;
   } kwsa_req_type;

   typedef struct packed {
      logic [31:0]        out_user;
      logic [63:0]        out_topic_upper;
      logic [47:0]        out_topic_lower;
      logic signed [31:0] total_score;
      logic               entry_valid;
      logic               overflow_seen;
      logic               last_item;
   } kwsa_rsp_type;

   typedef struct packed {
      logic [31:0] user;
      logic [63:0] topic_upper;
      logic [47:0] topic_lower;
   } kwsa_key_type;

   typedef struct packed {
      kwsa_key_type       key;
      logic signed [31:0] score;
   } kwsa_entry_type;

   typedef struct packed {
      logic               valid;
      logic               hit;
      kwsa_key_type       key;
      logic signed [7:0]  weight;
   } kwsa_query_type;

   typedef struct packed {
      logic live;
      logic wr_en;
      logic shift_en;
   } kwsa_cell_ctrl_type;

   function automatic logic signed [7:0] weight_of(input logic [7:0] code);
      logic signed [7:0] w;
      case (code)
         CODE_P:  w = WEIGHT_P;
         CODE_S:  w = WEIGHT_S;
         CODE_C:  w = WEIGHT_C;
         CODE_L:  w = WEIGHT_L;
         CODE_D:  w = WEIGHT_D;
         default: w = 8'sd0;
      endcase
      return w;
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                  input logic signed [7:0] w);
      logic signed [32:0] s;
      logic signed [31:0] r;
      s = 33'(acc) + 33'(w);
      if (s[32] != s[31]) begin
         r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/kwsa_cell.sv
`default_nettype none

module kwsa_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  kwsa_pkg::kwsa_cell_ctrl_type ctrl,
   input  kwsa_pkg::kwsa_query_type     query_in,
   output kwsa_pkg::kwsa_query_type     query_out,
   input  kwsa_pkg::kwsa_entry_type     shift_in,
   input  kwsa_pkg::kwsa_entry_type     insert_in,
   output kwsa_pkg::kwsa_entry_type     entry_out
);

   kwsa_pkg::kwsa_entry_type entry_ff;
   kwsa_pkg::kwsa_entry_type entry_in;
   kwsa_pkg::kwsa_query_type query_ff;
   kwsa_pkg::kwsa_query_type query_in_next;
   logic                     match;

   always_comb begin
      match = ctrl.live && query_in.valid && (query_in.key == entry_ff.key);
      entry_in = entry_ff;
      if (ctrl.shift_en) begin
         entry_in = shift_in;
      end else if (ctrl.wr_en) begin
         entry_in = insert_in;
      end else if (match) begin
         entry_in.score = kwsa_pkg::sat_add(entry_ff.score, query_in.weight);
      end
      query_in_next = query_in;
      query_in_next.hit = query_in.hit | match;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         query_ff <= '0;
      end else begin
         query_ff <= query_in_next;
      end
   end

   assign query_out = query_ff;
   assign entry_out = entry_ff;

endmodule

`default_nettype wire

### sv/keyed_weighted_score_accumulator_top.sv
// Group-by-sum table keyed on user and topic, with saturating 32-bit totals.
// A transaction is accepted at a rising edge where start is high and busy is low.
// An add transaction travels down a row of TABLE_DEPTH cells, one cell per cycle;
// each live cell compares its key and adds the weight on a match. At the end of
// the row an unmatched key is written into the next free cell, or dropped with
// the sticky overflow flag set when the table is full.
// An add keeps busy high until its query has passed the whole cell row, so a new
// add is not taken before the last one is through; an add gives no result.
// A dump shifts the row toward cell 0 once per cycle and emits cell 0 each cycle,
// so N stored entries give N results on consecutive cycles, the last marked by
// last_item; the first passes the state register and then the result register.
// An empty table gives a single result with entry_valid low. A dump holds busy
// until its last result is registered, then clears the table and overflow flag.
// Each result is shown for one cycle with rsp_valid high; the receiver cannot
// stall it. Reset empties the table and clears the overflow flag at once.

`default_nettype none

module keyed_weighted_score_accumulator_top #(
   parameter int TABLE_DEPTH = kwsa_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  kwsa_pkg::kwsa_req_type req_data,
   output logic                   rsp_valid,
   output kwsa_pkg::kwsa_rsp_type rsp_data
);

   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DUMP   = 2'd2;

   logic [1:0]              state_ff;
   logic [1:0]              state_in;
   logic [FILL_W-1:0]       fill_ff;
   logic [FILL_W-1:0]       fill_in;
   logic                    dropped_ff;
   logic                    dropped_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   kwsa_pkg::kwsa_rsp_type  rsp_ff;
   kwsa_pkg::kwsa_rsp_type  rsp_in;

   logic                     accept;
   logic                     finalize;
   logic                     dump_step;
   kwsa_pkg::kwsa_query_type query_chain [TABLE_DEPTH+1];
   kwsa_pkg::kwsa_entry_type entry_chain [TABLE_DEPTH];
   kwsa_pkg::kwsa_entry_type insert_entry;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      query_chain[0].valid             = accept && (req_data.cmd == kwsa_pkg::CMD_ADD);
      query_chain[0].hit               = 1'b0;
      query_chain[0].key.user          = req_data.user_key;
      query_chain[0].key.topic_upper   = req_data.topic_upper;
      query_chain[0].key.topic_lower   = req_data.topic_lower;
      query_chain[0].weight            = kwsa_pkg::weight_of(req_data.action_code);
   end

   assign finalize  = query_chain[TABLE_DEPTH].valid && !query_chain[TABLE_DEPTH].hit;
   assign dump_step = (state_ff == ST_DUMP) && (fill_ff != '0);

   always_comb begin
      insert_entry.key   = query_chain[TABLE_DEPTH].key;
      insert_entry.score = {{24{query_chain[TABLE_DEPTH].weight[7]}},
                            query_chain[TABLE_DEPTH].weight};
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      kwsa_pkg::kwsa_cell_ctrl_type ctrl;
      kwsa_pkg::kwsa_entry_type     shift_src;

      always_comb begin
         ctrl.live     = (FILL_W'(i) < fill_ff);
         ctrl.wr_en    = finalize && (fill_ff == FILL_W'(i));
         ctrl.shift_en = dump_step;
      end

      if (i < TABLE_DEPTH - 1) begin : g_inner
         assign shift_src = entry_chain[i+1];
      end else begin : g_tail
         assign shift_src = '0;
      end

      kwsa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .query_in  (query_chain[i]),
         .query_out (query_chain[i+1]),
         .shift_in  (shift_src),
         .insert_in (insert_entry),
         .entry_out (entry_chain[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.cmd == kwsa_pkg::CMD_DUMP) ? ST_DUMP : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (query_chain[TABLE_DEPTH].valid) begin
               state_in = ST_IDLE;
               if (finalize) begin
                  if (fill_ff == FILL_W'(TABLE_DEPTH)) begin
                     dropped_in = 1'b1;
                  end else begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            end
         end
         ST_DUMP: begin
            rsp_valid_in          = 1'b1;
            rsp_in.overflow_seen  = dropped_ff;
            if (fill_ff == '0) begin
               rsp_in.last_item = 1'b1;
            end else begin
               rsp_in.out_user        = entry_chain[0].key.user;
               rsp_in.out_topic_upper = entry_chain[0].key.topic_upper;
               rsp_in.out_topic_lower = entry_chain[0].key.topic_lower;
               rsp_in.total_score     = entry_chain[0].score;
               rsp_in.entry_valid     = 1'b1;
               rsp_in.last_item       = (fill_ff == FILL_W'(1));
            end
            if (rsp_in.last_item) begin
               state_in   = ST_IDLE;
               fill_in    = '0;
               dropped_in = 1'b0;
            end else begin
               fill_in = fill_ff - FILL_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### sv/kwsa_checker.sv
`default_nettype none

`include "keyed_weighted_score_accumulator_top_defines.svh"

module kwsa_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire kwsa_pkg::kwsa_req_type req_data,
   input wire logic                   rsp_valid,
   input wire kwsa_pkg::kwsa_rsp_type rsp_data
);

   logic dump_seen_in;
   logic dump_seen_ff;

   assign dump_seen_in = start && !busy && (req_data.cmd == kwsa_pkg::CMD_DUMP);

   always_ff @(posedge clock) begin
      if (reset) begin
         dump_seen_ff <= 1'b0;
      end else begin
         dump_seen_ff <= dump_seen_in;
      end
   end

   `KWSA_ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy, busy)
   `KWSA_ASSERT_NEXT(a_dump_answers_next, clock, reset, dump_seen_ff, rsp_valid)
   `KWSA_ASSERT_NEXT(a_last_ends_dump, clock, reset, rsp_valid && rsp_data.last_item, !rsp_valid)
   `KWSA_ASSERT_IMPLY(a_empty_is_last, clock, reset, rsp_valid && !rsp_data.entry_valid, rsp_data.last_item)

endmodule

bind keyed_weighted_score_accumulator_top kwsa_checker u_kwsa_checker (.*);

`default_nettype wire
